/* hw/rtl/rtd_pkg.sv */
// Shared types, constants and lookup functions for the route turn detector.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none
package rtd_pkg;

    localparam int CORDIC_STEPS    = 24;
    localparam int COORD_FRAC_BITS = 23;
    localparam int STEP_W          = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam int XY_W  = 36;
    localparam int Z_W   = 28;
    localparam int LEN_W = 36;
    localparam int P_W   = 60;
    localparam int SUM_W = 48;

    localparam logic [16:0] FULL_TURN = 17'd92160;
    localparam logic signed [17:0] HALF_TURN_S = 18'sd46080;
    localparam logic signed [17:0] FULL_TURN_S = 18'sd92160;
    localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] Z_BIAS = Z_W'(360 * 65536 + 128);
    localparam logic [27:0] INV_GAIN_Q28 = 28'd163008219;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [2:0] MAN_ARRIVE       = 3'd0;
    localparam logic [2:0] MAN_RIGHT        = 3'd1;
    localparam logic [2:0] MAN_SLIGHT_RIGHT = 3'd2;
    localparam logic [2:0] MAN_LEFT         = 3'd3;
    localparam logic [2:0] MAN_SLIGHT_LEFT  = 3'd4;

    localparam logic [1:0] REG_KM_PER_DEGREE     = 2'd0;
    localparam logic [1:0] REG_MIN_TURN_ANGLE    = 2'd1;
    localparam logic [1:0] REG_SHARP_RIGHT_ANGLE = 2'd2;
    localparam logic [1:0] REG_SHARP_LEFT_ANGLE  = 2'd3;

    typedef struct packed {
        logic signed [31:0] lng;
        logic signed [31:0] lat;
        logic               first;
        logic               last;
    } point_t;

    typedef struct packed {
        logic [23:0]        km_per_degree;
        logic [15:0]        min_turn_angle;
        logic [15:0]        sharp_right_angle;
        logic signed [16:0] sharp_left_angle;
    } cfg_t;

    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        logic [21:0] a;
        case (idx)
            5'd0:  a = 22'd2949120;
            5'd1:  a = 22'd1740967;
            5'd2:  a = 22'd919879;
            5'd3:  a = 22'd466945;
            5'd4:  a = 22'd234379;
            5'd5:  a = 22'd117304;
            5'd6:  a = 22'd58666;
            5'd7:  a = 22'd29335;
            5'd8:  a = 22'd14668;
            5'd9:  a = 22'd7334;
            5'd10: a = 22'd3667;
            5'd11: a = 22'd1833;
            5'd12: a = 22'd917;
            5'd13: a = 22'd458;
            5'd14: a = 22'd229;
            5'd15: a = 22'd115;
            5'd16: a = 22'd57;
            5'd17: a = 22'd29;
            5'd18: a = 22'd14;
            5'd19: a = 22'd7;
            5'd20: a = 22'd4;
            5'd21: a = 22'd2;
            5'd22: a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/route_turn_detector_unit.sv */
// A point that is neither a first point nor dropped runs through the segment engine's
// one-step-per-cycle CORDIC loop, then the multiply and finish states; others finish in IDLE.
// The engine takes a new point only once the last is through; a two-beat input queue and a
// one-beat result slot decouple both sides. A new point starts only when the slot is free.
// Reset (rst_n low, asynchronous): queues empty, registers at defaults, scan idle
// until a first point. Top level: config port, input queue, segment engine.
`default_nettype none
module route_turn_detector_unit
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] point_lng,
    input  wire logic signed [31:0] point_lat,
    input  wire logic               first_point,
    input  wire logic               last_point,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    turn_found,
    output logic [2:0]              maneuver,
    output logic [31:0]             distance_m
);

    rtd_pkg::cfg_t   cfg_reg;
    rtd_pkg::point_t point_in, item;
    logic item_valid, item_take, res_valid, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign point_in = '{lng: point_lng, lat: point_lat, first: first_point, last: last_point};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.km_per_degree     <= 24'd7295468;
            cfg_reg.min_turn_angle    <= 16'd6400;
            cfg_reg.sharp_right_angle <= 16'd17920;
            cfg_reg.sharp_left_angle  <= -17'sd17920;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                rtd_pkg::REG_KM_PER_DEGREE:     cfg_reg.km_per_degree     <= pwdata[23:0];
                rtd_pkg::REG_MIN_TURN_ANGLE:    cfg_reg.min_turn_angle    <= pwdata[15:0];
                rtd_pkg::REG_SHARP_RIGHT_ANGLE: cfg_reg.sharp_right_angle <= pwdata[15:0];
                rtd_pkg::REG_SHARP_LEFT_ANGLE:  cfg_reg.sharp_left_angle  <= pwdata[16:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            rtd_pkg::REG_KM_PER_DEGREE:     prdata = {8'd0, cfg_reg.km_per_degree};
            rtd_pkg::REG_MIN_TURN_ANGLE:    prdata = {16'd0, cfg_reg.min_turn_angle};
            rtd_pkg::REG_SHARP_RIGHT_ANGLE: prdata = {16'd0, cfg_reg.sharp_right_angle};
            rtd_pkg::REG_SHARP_LEFT_ANGLE:  prdata = 32'(cfg_reg.sharp_left_angle);
            default:                        prdata = '0;
        endcase
    end

    rtd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .point_in   (point_in),
        .full       (full),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    rtd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res_pop    (pop),
        .turn_found (turn_found),
        .maneuver   (maneuver),
        .distance_m (distance_m)
    );

    assign empty = !res_valid;

    a_take_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> res_valid && !pop ? 1'b0 : 1'b1)
        else $error("item taken while result slot occupied");

    a_take_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> item_valid)
        else $error("engine took from empty queue");

    a_arrive_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !turn_found) |-> (maneuver == rtd_pkg::MAN_ARRIVE))
        else $error("arrive result with turn maneuver");

endmodule
`default_nettype wire

/* hw/rtl/rtd_front.sv */
// Input side: two-beat point queue in front of the segment engine.
// Depends on rtd_pkg.
`default_nettype none
module rtd_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rtd_pkg::point_t point_in,
    output logic                 full,
    output logic                 item_valid,
    output rtd_pkg::point_t      item,
    input  wire logic            item_take
);

    rtd_pkg::point_t slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[0];
    assign do_push    = push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !(item_take && item_valid))
            count_next = count_reg + 2'd1;
        else if (!do_push && item_take && item_valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take && item_valid)
        begin
            slot_reg[0] <= slot_reg[1];
            if (do_push && count_reg == 2'd1)
                slot_reg[0] <= point_in;
            if (do_push && count_reg == 2'd2)
                slot_reg[1] <= point_in;
        end
        else if (do_push)
        begin
            if (count_reg == 2'd0)
                slot_reg[0] <= point_in;
            else
                slot_reg[1] <= point_in;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rtd_back.sv */
// Segment engine: iterative CORDIC, split multiplies, scan state and result slot.
// Depends on rtd_pkg.
`default_nettype none
module rtd_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rtd_pkg::cfg_t   cfg,
    input  wire logic            item_valid,
    input  wire rtd_pkg::point_t item,
    output logic                 item_take,
    output logic                 res_valid,
    input  wire logic            res_pop,
    output logic                 turn_found,
    output logic [2:0]           maneuver,
    output logic [31:0]          distance_m
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ITER, ST_MUL0, ST_MUL1, ST_MET0, ST_MET1, ST_MET2, ST_FIN
    } state_t;

    state_t state_reg;
    logic [rtd_pkg::STEP_W-1:0] iter_reg;
    logic signed [rtd_pkg::XY_W-1:0] x_reg, y_reg;
    logic signed [rtd_pkg::Z_W-1:0]  z_reg;
    logic        zero_reg, last_reg;
    logic signed [31:0] cur_lng_reg, cur_lat_reg;
    logic signed [31:0] prev_lng_reg, prev_lat_reg;
    logic [16:0] prev_heading_reg, head_reg;
    logic [1:0]  seen_reg;
    logic [rtd_pkg::SUM_W-1:0] sum_reg;
    logic        done_reg;
    logic [45:0] acc_reg;
    logic [rtd_pkg::LEN_W-1:0] len_reg;
    logic [rtd_pkg::P_W-1:0]   p_reg;
    logic [46:0] whole_reg;
    logic [32:0] frac_reg;
    logic        res_valid_reg, found_reg;
    logic [2:0]  man_reg;
    logic [31:0] dist_reg;

    logic signed [32:0] dx, dy;
    logic signed [rtd_pkg::XY_W-1:0] xs, ys;
    logic signed [rtd_pkg::Z_W-1:0]  ang, zt;
    logic [19:0] hraw;
    logic [16:0] hmod;
    logic [63:0] len_full;
    logic [rtd_pkg::SUM_W:0] sum_add, r_wide;
    logic [46:0] seg;
    logic [rtd_pkg::SUM_W-1:0] sum_sat;
    logic [31:0] metres_now;
    logic signed [17:0] dh, dw, mag, min_s, sr_s, sl_s;
    logic [2:0]  man_sel;

    assign item_take  = (state_reg == ST_IDLE) && item_valid && !res_valid_reg;
    assign res_valid  = res_valid_reg;
    assign turn_found = found_reg;
    assign maneuver   = man_reg;
    assign distance_m = dist_reg;

    assign dx  = 33'(item.lng) - 33'(prev_lng_reg);
    assign dy  = 33'(item.lat) - 33'(prev_lat_reg);
    assign xs  = x_reg >>> iter_reg;
    assign ys  = y_reg >>> iter_reg;
    assign ang = rtd_pkg::Z_W'(rtd_pkg::atan_lut(5'(iter_reg)));

    assign zt   = z_reg + rtd_pkg::Z_BIAS;
    assign hraw = zt[27:8];
    assign hmod = (hraw >= 20'(rtd_pkg::FULL_TURN)) ? 17'(hraw - 20'(rtd_pkg::FULL_TURN))
                                                     : hraw[16:0];

    assign len_full = 64'(acc_reg)
                    + (64'(48'(x_reg[35:18]) * 48'(rtd_pkg::INV_GAIN_Q28)) << 18)
                    + (64'd1 << 27);

    assign seg     = whole_reg + 47'(frac_reg);
    assign sum_add = 49'(sum_reg) + 49'(seg);
    assign sum_sat = sum_add[rtd_pkg::SUM_W] ? rtd_pkg::SUM_MAX : sum_add[rtd_pkg::SUM_W-1:0];
    assign r_wide  = (49'(sum_reg) + 49'd32768) >> 16;
    assign metres_now = (r_wide[32:0] > 33'h0FFFFFFFF) ? 32'hFFFFFFFF : r_wide[31:0];

    assign dh    = $signed({1'b0, head_reg}) - $signed({1'b0, prev_heading_reg});
    assign dw    = (dh > rtd_pkg::HALF_TURN_S) ? dh - rtd_pkg::FULL_TURN_S :
                   (dh < -rtd_pkg::HALF_TURN_S) ? dh + rtd_pkg::FULL_TURN_S : dh;
    assign mag   = dw[17] ? -dw : dw;
    assign min_s = $signed({2'b00, cfg.min_turn_angle});
    assign sr_s  = $signed({2'b00, cfg.sharp_right_angle});
    assign sl_s  = 18'(cfg.sharp_left_angle);

    always_comb
    begin
        if (dw > sr_s)
            man_sel = rtd_pkg::MAN_RIGHT;
        else if (dw > min_s)
            man_sel = rtd_pkg::MAN_SLIGHT_RIGHT;
        else if (dw < sl_s)
            man_sel = rtd_pkg::MAN_LEFT;
        else
            man_sel = rtd_pkg::MAN_SLIGHT_LEFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            iter_reg         <= '0;
            prev_lng_reg     <= '0;
            prev_lat_reg     <= '0;
            prev_heading_reg <= '0;
            seen_reg         <= '0;
            sum_reg          <= '0;
            done_reg         <= 1'b1;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (res_pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_take)
                    begin
                        cur_lng_reg <= item.lng;
                        cur_lat_reg <= item.lat;
                        last_reg    <= item.last;
                        zero_reg    <= (dx == 33'sd0) && (dy == 33'sd0);
                        iter_reg    <= '0;
                        if (item.first)
                        begin
                            prev_lng_reg     <= item.lng;
                            prev_lat_reg     <= item.lat;
                            prev_heading_reg <= '0;
                            seen_reg         <= 2'd1;
                            sum_reg          <= '0;
                            done_reg         <= item.last;
                            if (item.last)
                            begin
                                res_valid_reg <= 1'b1;
                                found_reg     <= 1'b0;
                                man_reg       <= rtd_pkg::MAN_ARRIVE;
                                dist_reg      <= '0;
                            end
                        end
                        else if (!done_reg)
                        begin
                            if (dy < 0)
                            begin
                                x_reg <= -rtd_pkg::XY_W'(dy);
                                y_reg <= -rtd_pkg::XY_W'(dx);
                                z_reg <= rtd_pkg::Z_HALF;
                            end
                            else
                            begin
                                x_reg <= rtd_pkg::XY_W'(dy);
                                y_reg <= rtd_pkg::XY_W'(dx);
                                z_reg <= '0;
                            end
                            state_reg <= ST_ITER;
                        end
                    end
                end
                ST_ITER:
                begin
                    if (!y_reg[rtd_pkg::XY_W-1])
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + ang;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - ang;
                    end
                    if (iter_reg == rtd_pkg::STEP_W'(rtd_pkg::CORDIC_STEPS - 1))
                        state_reg <= ST_MUL0;
                    else
                        iter_reg <= iter_reg + 1'b1;
                end
                ST_MUL0:
                begin
                    acc_reg   <= 46'(x_reg[17:0]) * 46'(rtd_pkg::INV_GAIN_Q28);
                    head_reg  <= zero_reg ? 17'd0 : hmod;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    len_reg   <= zero_reg ? '0 : rtd_pkg::LEN_W'(len_full >> 28);
                    state_reg <= ST_MET0;
                end
                ST_MET0:
                begin
                    p_reg     <= rtd_pkg::P_W'(42'(len_reg[17:0]) * 42'(cfg.km_per_degree));
                    state_reg <= ST_MET1;
                end
                ST_MET1:
                begin
                    p_reg <= p_reg + (rtd_pkg::P_W'(42'(len_reg[35:18])
                                      * 42'(cfg.km_per_degree)) << 18);
                    state_reg <= ST_MET2;
                end
                ST_MET2:
                begin
                    whole_reg <= 47'(p_reg >> rtd_pkg::COORD_FRAC_BITS) * 47'd1000;
                    frac_reg  <= 33'((43'(p_reg[rtd_pkg::COORD_FRAC_BITS-1:0]) * 43'd1000)
                                     >> rtd_pkg::COORD_FRAC_BITS);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    state_reg <= ST_IDLE;
                    if (seen_reg == 2'd2 && mag > min_s)
                    begin
                        res_valid_reg <= 1'b1;
                        found_reg     <= 1'b1;
                        man_reg       <= man_sel;
                        dist_reg      <= metres_now;
                        done_reg      <= 1'b1;
                    end
                    else
                    begin
                        sum_reg          <= sum_sat;
                        prev_heading_reg <= head_reg;
                        prev_lng_reg     <= cur_lng_reg;
                        prev_lat_reg     <= cur_lat_reg;
                        if (seen_reg != 2'd2)
                            seen_reg <= seen_reg + 2'd1;
                        if (last_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            found_reg     <= 1'b0;
                            man_reg       <= rtd_pkg::MAN_ARRIVE;
                            done_reg      <= 1'b1;
                            dist_reg      <= '0;
                            if (seen_reg == 2'd2)
                            begin
                                dist_reg <= ((49'(sum_sat) + 49'd32768) >> 16) > 49'h0FFFFFFFF
                                            ? 32'hFFFFFFFF
                                            : 32'((49'(sum_sat) + 49'd32768) >> 16);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sim/route_turn_checker.sv */
// Checker for the route turn detector: watches the point and result queues,
// predicts each result with its own CORDIC model and compares field by field.
// Depends on rtd_pkg for register indexes, maneuver codes and CORDIC_STEPS.
`timescale 1ns / 1ps
module route_turn_checker
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic signed [31:0] point_lng,
    input  wire logic signed [31:0] point_lat,
    input  wire logic               first_point,
    input  wire logic               last_point,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic               turn_found,
    input  wire logic [2:0]         maneuver,
    input  wire logic [31:0]        distance_m,
    output int                      errors,
    output int                      pending,
    output int                      results_seen
);
    typedef struct {
        bit        found;
        bit [2:0]  man;
        bit [31:0] metres;
    } turn_result_t;

    turn_result_t turn_q[$];

    bit [23:0]        km_deg;
    bit [15:0]        min_ang;
    bit [15:0]        right_ang;
    bit signed [16:0] left_ang;

    longint    last_lng, last_lat;
    int        last_head;
    int        seen;
    bit [47:0] route_sum;
    bit        idle_scan;

    const longint ATAN_TAB[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0};

    assign pending = turn_q.size();

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    task automatic segment(input longint de, input longint dn,
                           output int head, output bit [63:0] len);
        longint x, y, z, xs, ys;
        x = dn; y = de; z = 0;
        if (x == 0 && y == 0)
        begin
            head = 0; len = 0;
            return;
        end
        if (x < 0)
        begin
            x = -x; y = -y; z = 180 * 65536;
        end
        for (int i = 0; i < rtd_pkg::CORDIC_STEPS; i++)
        begin
            xs = asr(x, i); ys = asr(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        head = int'(((longint'(z) + 360 * 65536 + 128) >>> 8) % 92160);
        len = (64'(x) * 64'd163008219 + (64'd1 << 27)) >> 28;
    endtask

    function automatic bit [31:0] sum_to_m(bit [47:0] s);
        bit [63:0] r;
        r = (64'(s) + 64'd32768) >> 16;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    task automatic add_result(bit f, bit [2:0] m, bit [31:0] d);
        turn_result_t r;
        r.found = f; r.man = m; r.metres = d;
        turn_q = {turn_q, r};
        idle_scan = 1;
    endtask

    task automatic predict(longint lng, longint lat, bit fst, bit lst);
        int        head, d, mag, old_seen;
        bit [63:0] len, p, seg;
        bit [2:0]  m;
        if (fst)
        begin
            last_lng = lng; last_lat = lat; last_head = 0;
            seen = 1; route_sum = 0; idle_scan = 0;
            if (lst)
                add_result(0, rtd_pkg::MAN_ARRIVE, 0);
            return;
        end
        if (idle_scan)
            return;
        segment(lng - last_lng, lat - last_lat, head, len);
        p = len * 64'(km_deg);
        seg = (p >> 23) * 1000 + (((p & 64'h7F_FFFF) * 1000) >> 23);
        old_seen = seen;
        if (old_seen >= 2)
        begin
            d = head - last_head;
            if (d > 46080)
                d -= 92160;
            else if (d < -46080)
                d += 92160;
            mag = (d < 0) ? -d : d;
            if (mag > int'(min_ang))
            begin
                if (d > int'(right_ang))
                    m = rtd_pkg::MAN_RIGHT;
                else if (d > int'(min_ang))
                    m = rtd_pkg::MAN_SLIGHT_RIGHT;
                else if (d < int'(left_ang))
                    m = rtd_pkg::MAN_LEFT;
                else
                    m = rtd_pkg::MAN_SLIGHT_LEFT;
                add_result(1, m, sum_to_m(route_sum));
                return;
            end
        end
        if (64'h FFFF_FFFF_FFFF - 64'(route_sum) < seg)
            route_sum = '1;
        else
            route_sum = route_sum + seg[47:0];
        last_head = head; last_lng = lng; last_lat = lat;
        if (seen < 2)
            seen++;
        if (lst)
            add_result(0, rtd_pkg::MAN_ARRIVE, (old_seen >= 2) ? sum_to_m(route_sum) : 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            km_deg = 24'd7295468; min_ang = 16'd6400;
            right_ang = 16'd17920; left_ang = -17'sd17920;
            last_lng = 0; last_lat = 0; last_head = 0; seen = 0;
            route_sum = 0; idle_scan = 1;
            errors = 0; results_seen = 0;
            turn_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    rtd_pkg::REG_KM_PER_DEGREE:     km_deg = pwdata[23:0];
                    rtd_pkg::REG_MIN_TURN_ANGLE:    min_ang = pwdata[15:0];
                    rtd_pkg::REG_SHARP_RIGHT_ANGLE: right_ang = pwdata[15:0];
                    rtd_pkg::REG_SHARP_LEFT_ANGLE:  left_ang = pwdata[16:0];
                    default:                        ;
                endcase
            end
            if (!empty && pop)
            begin
                results_seen++;
                if (turn_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    turn_result_t e;
                    e = turn_q.pop_front();
                    if (turn_found !== e.found)
                    begin
                        $error("turn_found expected %0d actual %0d", e.found, turn_found);
                        errors++;
                    end
                    if (maneuver !== e.man)
                    begin
                        $error("maneuver expected %0d actual %0d", e.man, maneuver);
                        errors++;
                    end
                    if (distance_m !== e.metres)
                    begin
                        $error("distance_m expected %0d actual %0d", e.metres, distance_m);
                        errors++;
                    end
                end
            end
            if (push && !full)
                predict(longint'(point_lng), longint'(point_lat), first_point, last_point);
        end
    end
endmodule

/* sim/tb_route_turn_detector_unit.sv */
// Testbench top for route_turn_detector_unit: drives routes and register writes
// under several idle patterns; route_turn_checker predicts and compares results.
// Depends on rtd_pkg, the block and the checker.
`timescale 1ns / 1ps
module tb_route_turn_detector_unit;
    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [3:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push = 0;
    logic               full;
    logic signed [31:0] point_lng = 0, point_lat = 0;
    logic               first_point = 0, last_point = 0;
    logic               empty;
    logic               pop = 0;
    logic               turn_found;
    logic [2:0]         maneuver;
    logic [31:0]        distance_m;
    int                 errors, pending, results_seen;
    int                 send_idle = 0, recv_stall = 0;
    int                 beats = 0;
    longint             cycles = 0;

    localparam longint CYCLE_LIMIT = 2000000;

    always #6 clk = ~clk;

    route_turn_detector_unit DUT (.*);

    route_turn_checker u_check (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_stall);

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_point(logic signed [31:0] lng, logic signed [31:0] lat,
                              bit fst, bit lst);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1; point_lng <= lng; point_lat <= lat;
        first_point <= fst; last_point <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats++;
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_regs(logic [23:0] k, logic [15:0] mn, logic [15:0] r,
                            logic signed [16:0] l);
        reg_write(rtd_pkg::REG_KM_PER_DEGREE, 32'(k));
        reg_write(rtd_pkg::REG_MIN_TURN_ANGLE, 32'(mn));
        reg_write(rtd_pkg::REG_SHARP_RIGHT_ANGLE, 32'(r));
        reg_write(rtd_pkg::REG_SHARP_LEFT_ANGLE, 32'(unsigned'(l)));
    endtask

    function automatic logic signed [31:0] coord_step(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    task automatic random_route(int npts);
        logic signed [31:0] lng, lat;
        int span;
        span = ($urandom_range(9) == 0) ? 32'h3FFF_FFFF : (1 << $urandom_range(24, 4));
        lng = $urandom; lat = $urandom;
        if ($urandom_range(3) == 0)
        begin
            lng = lng >>> 8; lat = lat >>> 8;
        end
        send_point(lng, lat, 1, npts == 1);
        for (int i = 1; i < npts; i++)
        begin
            if ($urandom_range(15) == 0)
            begin
                lng = $urandom; lat = $urandom;
            end
            else if ($urandom_range(11) != 0)
            begin
                lng = lng + coord_step(span); lat = lat + coord_step(span);
            end
            send_point(lng, lat, $urandom_range(29) == 0, i == npts - 1);
        end
    endtask

    task automatic phase(int snd, int rcv, int routes);
        send_idle = snd; recv_stall = rcv;
        for (int r = 0; r < routes; r++)
        begin
            if ($urandom_range(19) == 0)
                send_point($urandom, $urandom, 0, 1'($urandom_range(1)));
            else
                random_route($urandom_range(1, 9));
        end
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        send_point(5, 5, 0, 1);
        send_point(0, 0, 1, 1);
        send_point(0, 0, 1, 0);
        send_point(0, 0, 0, 1);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1);
        send_point(0, 0, 1, 0);
        send_point(0, 0, 0, 0);
        send_point(0, 1000000, 0, 0);
        send_point(1000000, 1000000, 0, 0);
        send_point(1, 1, 0, 1);
        send_point(0, 0, 1, 0);
        send_point(0, 1000000, 0, 0);
        send_point(-1000000, 1000000, 0, 0);
        send_point(0, 0, 1, 0);
        send_point(0, 1000000, 0, 0);
        send_point(300000, 2000000, 0, 1);
        send_point(0, 0, 1, 0);
        send_point(0, -1000000, 0, 0);
        send_point(0, 0, 0, 1);
        drain();

        phase(0, 0, 40);
        set_regs(24'hFF_FFFF, 16'd0, 16'd0, 17'sd0);
        phase(84, 0, 30);
        set_regs(24'd0, 16'd46080, 16'd46080, -17'sd46080);
        phase(0, 84, 25);
        set_regs(24'd7295468, 16'd1280, 16'd23040, -17'sd23040);
        phase(34, 34, 30);
        set_regs(24'($urandom), 16'($urandom_range(46080)), 16'($urandom_range(46080)),
                 -17'($urandom_range(46080)));
        phase(0, 0, 30);
        set_regs(24'd7295468, 16'd6400, 16'd17920, -17'sd17920);
        phase(0, 0, 30);

        $display("Covered %0d point beats and %0d result beats over six register settings",
                 beats, results_seen);
        $display("and four idle patterns, including degenerate and saturating routes.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
